@@ src/gbn_pkg.sv @@
// Shared constants, types and codes of the go-back-N sender.
package gbn_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SEQ_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int WSZ_BITS   = 5;
  localparam int TMR_BITS   = 16;
  localparam int CKS_BITS   = 18;
  localparam int BSUM_BITS  = 13;   // twenty bytes of 255 at most
  localparam int CFG_BITS   = 16;

  localparam int CMDQ_DEPTH     = 2;
  localparam int CMDQ_PTR_BITS  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_BITS  = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH     = 4;
  localparam int RESQ_PTR_BITS  = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_BITS  = $clog2(RESQ_DEPTH + 1);

  localparam logic [WSZ_BITS-1:0] WINDOW_RESET  = WSZ_BITS'(8);
  localparam logic [TMR_BITS-1:0] TIMEOUT_RESET = TMR_BITS'(25);

  localparam logic KIND_SENT    = 1'b0;
  localparam logic KIND_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    OP_MSG  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_TIMEOUT     = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_RESEND = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
  } pay_t;

  typedef struct packed {
    opcode_t                op;
    logic [SEQ_BITS-1:0]    ack;
    logic [BSUM_BITS-1:0]   bsum;
    pay_t                   pay;
  } cmd_t;

  typedef struct packed {
    logic [BSUM_BITS-1:0]   bsum;
    pay_t                   pay;
  } entry_t;

  typedef struct packed {
    logic                   kind;
    logic [SEQ_BITS-1:0]    seq;
    logic [CKS_BITS-1:0]    cks;
    pay_t                   pay;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic                   valid;
    cfg_idx_t               index;
    logic [CFG_BITS-1:0]    data;
  } cfg_wr_t;

endpackage

@@ src/gbn_front.sv @@
// Front end: registers an input word, sums payload bytes, drops bad ACKs.
module gbn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_opcode,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  in_seq,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  in_ack,
  input  logic [gbn_pkg::CKS_BITS-1:0]  in_checksum,
  input  logic [63:0]                   in_payload_lo,
  input  logic [63:0]                   in_payload_mid,
  input  logic [31:0]                   in_payload_hi,
  output logic                          cmd_push,
  output gbn_pkg::cmd_t                 cmd_data,
  input  logic                          cmd_full
);
  import gbn_pkg::*;

  // Add the twenty payload bytes as a tree: eight lanes, then pairs.
  function automatic logic [BSUM_BITS-1:0] byte_sum(input pay_t p);
    logic [BSUM_BITS-1:0] lane [8];
    logic [BSUM_BITS-1:0] pair [4];
    for (int i = 0; i < 8; i++) begin
      lane[i] = BSUM_BITS'(p.lo[8*i +: 8]) + BSUM_BITS'(p.mid[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      lane[i] = lane[i] + BSUM_BITS'(p.hi[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      pair[i] = lane[2*i] + lane[2*i+1];
    end
    return (pair[0] + pair[1]) + (pair[2] + pair[3]);
  endfunction

  logic                  f_valid_r;
  logic [1:0]            f_op_r;
  logic [SEQ_BITS-1:0]   f_seq_r;
  logic [SEQ_BITS-1:0]   f_ack_r;
  logic [CKS_BITS-1:0]   f_cks_r;
  pay_t                  f_pay_r;
  logic [BSUM_BITS-1:0]  bsum;
  logic [CKS_BITS-1:0]   ack_sum;
  logic                  keep;
  logic                  free;
  logic                  accept;

  always_comb begin
    bsum    = byte_sum(f_pay_r);
    ack_sum = CKS_BITS'(f_seq_r) + CKS_BITS'(f_ack_r) + CKS_BITS'(bsum);
    unique case (f_op_r)
      OP_MSG:  keep = 1'b1;
      OP_ACK:  keep = (ack_sum == f_cks_r);
      OP_TICK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign free     = f_valid_r && (!keep || !cmd_full);
  assign full     = f_valid_r && !free;
  assign accept   = push && !full;
  assign cmd_push = f_valid_r && keep && !cmd_full;

  always_comb begin
    cmd_data.op   = opcode_t'(f_op_r);
    cmd_data.ack  = f_ack_r;
    cmd_data.bsum = bsum;
    cmd_data.pay  = f_pay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (free) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r      <= in_opcode;
      f_seq_r     <= in_seq;
      f_ack_r     <= in_ack;
      f_cks_r     <= in_checksum;
      f_pay_r.lo  <= in_payload_lo;
      f_pay_r.mid <= in_payload_mid;
      f_pay_r.hi  <= in_payload_hi;
    end
  end

endmodule

@@ src/gbn_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module gbn_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gbn_pkg::cmd_t  din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output gbn_pkg::cmd_t  dout
);
  import gbn_pkg::*;

  cmd_t                     mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_BITS-1:0] wp_r;
  logic [CMDQ_PTR_BITS-1:0] rp_r;
  logic [CMDQ_CNT_BITS-1:0] cnt_r;
  logic                     wr;
  logic                     rd;

  assign full  = (cnt_r == CMDQ_CNT_BITS'(CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CMDQ_CNT_BITS'(wr) - CMDQ_CNT_BITS'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

@@ src/gbn_res_fifo.sv @@
// Result queue that holds finished words until the receiver pops them.
module gbn_res_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  gbn_pkg::res_t                      din,
  output logic                               full,
  output logic [gbn_pkg::RESQ_CNT_BITS-1:0]  cnt,
  input  logic                               pop,
  output logic                               empty,
  output gbn_pkg::res_t                      dout
);
  import gbn_pkg::*;

  res_t                     mem_r [RESQ_DEPTH];
  logic [RESQ_PTR_BITS-1:0] wp_r;
  logic [RESQ_PTR_BITS-1:0] rp_r;
  logic [RESQ_CNT_BITS-1:0] cnt_r;
  logic                     wr;
  logic                     rd;

  assign full  = (cnt_r == RESQ_CNT_BITS'(RESQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + RESQ_CNT_BITS'(wr) - RESQ_CNT_BITS'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

@@ src/gbn_back.sv @@
// Back end: window and timer state, packet buffer, send and resend sequencer.
module gbn_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gbn_pkg::cfg_wr_t                   cfg,
  input  logic                               cmd_valid,
  input  gbn_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  input  logic                               res_full,
  input  logic [gbn_pkg::RESQ_CNT_BITS-1:0]  res_cnt,
  output logic                               res_push,
  output gbn_pkg::res_t                      res_data
);
  import gbn_pkg::*;

  bk_state_t              state_r, state_nxt;
  logic [SEQ_BITS-1:0]    base_r, base_nxt;
  logic [SEQ_BITS-1:0]    next_seq_r, next_seq_nxt;
  logic                   tmr_run_r, tmr_run_nxt;
  logic [TMR_BITS-1:0]    tmr_rem_r, tmr_rem_nxt;
  logic [SLOT_BITS-1:0]   base_slot_r, base_slot_nxt;
  logic [WIN_BITS-1:0]    idx_r, idx_nxt;
  logic [WIN_BITS-1:0]    rs_n_r, rs_n_nxt;
  logic                   rd_valid_r;
  logic [SEQ_BITS-1:0]    rd_seq_r, rd_seq_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic [WSZ_BITS-1:0]    win_size_r;
  logic [TMR_BITS-1:0]    timeout_r;

  entry_t                 mem [MAX_WINDOW];
  entry_t                 rd_data_r;
  logic                   mem_we;
  logic [SLOT_BITS-1:0]   wr_slot;
  entry_t                 wr_entry;
  logic                   rd_en;
  logic [SLOT_BITS-1:0]   rd_slot;

  logic [SEQ_BITS-1:0]    n;
  logic [SEQ_BITS-1:0]    win_eff;
  logic [SEQ_BITS-1:0]    d;
  logic [SEQ_BITS-1:0]    ack_next;
  logic                   exec;
  logic                   expire;
  logic                   issue;
  logic                   rs_last;

  assign n        = next_seq_r - base_r;
  assign win_eff  = (SEQ_BITS'(win_size_r) > SEQ_BITS'(MAX_WINDOW)) ?
                    SEQ_BITS'(MAX_WINDOW) : SEQ_BITS'(win_size_r);
  assign d        = cmd.ack - base_r;
  assign ack_next = cmd.ack + 1'b1;
  assign exec     = (state_r == BK_IDLE) && !rd_valid_r && cmd_valid && !res_full;
  assign expire   = exec && (cmd.op == OP_TICK) && tmr_run_r &&
                    !(tmr_rem_r > TMR_BITS'(1));
  assign issue    = (state_r == BK_RESEND) &&
                    ((RESQ_CNT_BITS + 1)'(res_cnt) + (RESQ_CNT_BITS + 1)'(rd_valid_r)
                     < (RESQ_CNT_BITS + 1)'(RESQ_DEPTH));
  assign rs_last  = (WIN_BITS'(idx_r + 1'b1) == rs_n_r);
  assign cmd_pop  = exec;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (expire && (n != '0)) begin
          state_nxt = BK_RESEND;
        end
      end
      BK_RESEND: begin
        if (issue && rs_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    base_nxt      = base_r;
    next_seq_nxt  = next_seq_r;
    tmr_run_nxt   = tmr_run_r;
    tmr_rem_nxt   = tmr_rem_r;
    base_slot_nxt = base_slot_r;
    idx_nxt       = idx_r;
    rs_n_nxt      = rs_n_r;
    rd_seq_nxt    = rd_seq_r;
    rd_last_nxt   = rd_last_r;
    mem_we        = 1'b0;
    wr_slot       = base_slot_r + n[SLOT_BITS-1:0];
    wr_entry.bsum = cmd.bsum;
    wr_entry.pay  = cmd.pay;
    rd_en         = 1'b0;
    rd_slot       = base_slot_r + idx_r[SLOT_BITS-1:0];
    res_push      = 1'b0;
    res_data      = '0;

    if (rd_valid_r) begin
      // drain a resent packet from the buffer read
      res_push      = 1'b1;
      res_data.kind = KIND_SENT;
      res_data.seq  = rd_seq_r;
      res_data.cks  = CKS_BITS'(rd_seq_r) + CKS_BITS'(rd_data_r.bsum);
      res_data.pay  = rd_data_r.pay;
      res_data.last = rd_last_r;
    end else if (exec) begin
      unique case (cmd.op)
        OP_MSG: begin
          res_push      = 1'b1;
          res_data.last = 1'b1;
          if (n < win_eff) begin
            mem_we        = 1'b1;
            res_data.kind = KIND_SENT;
            res_data.seq  = next_seq_r;
            res_data.cks  = CKS_BITS'(next_seq_r) + CKS_BITS'(cmd.bsum);
            res_data.pay  = cmd.pay;
            next_seq_nxt  = next_seq_r + 1'b1;
            if (n == '0) begin
              tmr_run_nxt = 1'b1;
              tmr_rem_nxt = timeout_r;
            end
          end else begin
            res_data.kind = KIND_REFUSED;
          end
        end
        OP_ACK: begin
          if (d < n) begin
            base_nxt      = ack_next;
            base_slot_nxt = base_slot_r + d[SLOT_BITS-1:0] + 1'b1;
            if (ack_next == next_seq_r) begin
              tmr_run_nxt = 1'b0;
            end else begin
              tmr_run_nxt = 1'b1;
              tmr_rem_nxt = timeout_r;
            end
          end
        end
        OP_TICK: begin
          if (tmr_run_r) begin
            if (tmr_rem_r > TMR_BITS'(1)) begin
              tmr_rem_nxt = tmr_rem_r - 1'b1;
            end else begin
              tmr_rem_nxt = timeout_r;
              idx_nxt     = '0;
              rs_n_nxt    = n[WIN_BITS-1:0];
            end
          end
        end
        default: ;
      endcase
    end

    if (issue) begin
      rd_en       = 1'b1;
      rd_seq_nxt  = base_r + SEQ_BITS'(idx_r);
      rd_last_nxt = rs_last;
      idx_nxt     = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      base_r      <= '0;
      next_seq_r  <= '0;
      tmr_run_r   <= 1'b0;
      tmr_rem_r   <= '0;
      base_slot_r <= '0;
      idx_r       <= '0;
      rs_n_r      <= '0;
      rd_valid_r  <= 1'b0;
      win_size_r  <= WINDOW_RESET;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_seq_r  <= next_seq_nxt;
      tmr_run_r   <= tmr_run_nxt;
      tmr_rem_r   <= tmr_rem_nxt;
      base_slot_r <= base_slot_nxt;
      idx_r       <= idx_nxt;
      rs_n_r      <= rs_n_nxt;
      rd_valid_r  <= rd_en;
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_WINDOW_SIZE: win_size_r <= cfg.data[WSZ_BITS-1:0];
          CFG_TIMEOUT:     timeout_r  <= cfg.data[TMR_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_seq_r  <= rd_seq_nxt;
    rd_last_r <= rd_last_nxt;
  end

  // Packet buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

endmodule

@@ src/go_back_n_sender.sv @@
// Top level of the go-back-N sender: front end, command queue, back end, result queue.
//
// Usage:
//   Input channel (push/full): each word is a new 20-byte message
//   (in_opcode 0), an arriving ACK packet (1) or one timer tick (2).
//   A word is taken at a clock edge with push high and full low.
//   Result channel (empty/pop): each word is a transmitted packet
//   (out_kind 0) or a refused message (out_kind 1); out_last marks the
//   final word caused by one input word. Pop takes the word on the ports.
//   Config channel (cfg_valid/cfg_ready): index 0 sets window size,
//   index 1 sets the timeout in ticks. Always ready; write only while idle.
// Timing:
//   A message is registered in the front end, then the command queue, then the
//   result queue before it shows. The front end takes one word per cycle while the
//   command queue has room; the back end executes one command per cycle while idle
//   and the result queue has room. On timer expiry the back end walks the outstanding
//   window through its registered-read packet buffer, one resent packet per cycle
//   while the result queue has room, and holds further commands until the burst ends.
// Reset (rst_n low, synchronous) empties both queues, clears window base,
//   next sequence and timer, and loads window size 8 and timeout 25.
// A stalled receiver fills the four-word result queue; the back end then
//   holds, the command queue fills, and full rises on the input side.
module go_back_n_sender (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_opcode,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  in_seq,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  in_ack,
  input  logic [gbn_pkg::CKS_BITS-1:0]  in_checksum,
  input  logic [63:0]                   in_payload_lo,
  input  logic [63:0]                   in_payload_mid,
  input  logic [31:0]                   in_payload_hi,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_kind,
  output logic [gbn_pkg::SEQ_BITS-1:0]  out_seq,
  output logic [gbn_pkg::CKS_BITS-1:0]  out_checksum,
  output logic [63:0]                   out_payload_lo,
  output logic [63:0]                   out_payload_mid,
  output logic [31:0]                   out_payload_hi,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  gbn_pkg::cfg_idx_t             cfg_index,
  input  logic [gbn_pkg::CFG_BITS-1:0]  cfg_data
);
  import gbn_pkg::*;

  cmd_t                      fe_cmd;
  logic                      fe_push;
  logic                      cq_full;
  logic                      cq_empty;
  cmd_t                      cq_dout;
  logic                      bk_pop;
  logic                      bk_push;
  res_t                      bk_res;
  logic                      rq_full;
  logic [RESQ_CNT_BITS-1:0]  rq_cnt;
  res_t                      rq_dout;
  cfg_wr_t                   cfg_wr;

  // Config writes land directly in the back end registers
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Register the input word, sum the payload and drop corrupt ACKs
  gbn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_opcode      (in_opcode),
    .in_seq         (in_seq),
    .in_ack         (in_ack),
    .in_checksum    (in_checksum),
    .in_payload_lo  (in_payload_lo),
    .in_payload_mid (in_payload_mid),
    .in_payload_hi  (in_payload_hi),
    .cmd_push       (fe_push),
    .cmd_data       (fe_cmd),
    .cmd_full       (cq_full)
  );

  // Decouple classification from execution
  gbn_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .din   (fe_cmd),
    .full  (cq_full),
    .pop   (bk_pop),
    .empty (cq_empty),
    .dout  (cq_dout)
  );

  // Execute: send, refuse, advance window, run timer, resend on expiry
  gbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_wr),
    .cmd_valid (!cq_empty),
    .cmd       (cq_dout),
    .cmd_pop   (bk_pop),
    .res_full  (rq_full),
    .res_cnt   (rq_cnt),
    .res_push  (bk_push),
    .res_data  (bk_res)
  );

  // Hold finished words for the receiver
  gbn_res_fifo u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push),
    .din   (bk_res),
    .full  (rq_full),
    .cnt   (rq_cnt),
    .pop   (pop),
    .empty (empty),
    .dout  (rq_dout)
  );

  assign out_kind        = rq_dout.kind;
  assign out_seq         = rq_dout.seq;
  assign out_checksum    = rq_dout.cks;
  assign out_payload_lo  = rq_dout.pay.lo;
  assign out_payload_mid = rq_dout.pay.mid;
  assign out_payload_hi  = rq_dout.pay.hi;
  assign out_last        = rq_dout.last;

endmodule

@@ src/gbn_checker.sv @@
// Port-level checker for the go-back-N sender, bound to the top level.
module gbn_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          empty,
  input  logic                          pop,
  input  logic                          out_kind,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  out_seq,
  input  logic [gbn_pkg::CKS_BITS-1:0]  out_checksum,
  input  logic                          out_last
);
  import gbn_pkg::*;

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A refusal is a single zeroed word
  a_refuse_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_REFUSED) |->
      (out_last && out_seq == '0 && out_checksum == '0))
    else $error("refused message word malformed");

  // A non-final sent word is followed by the next packet of the same burst
  a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_kind == KIND_SENT && !out_last) |=>
      (empty || (out_kind == KIND_SENT &&
                 out_seq == SEQ_BITS'($past(out_seq) + 1'b1))))
    else $error("resend burst out of order");

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_seq) && $stable(out_last)))
    else $error("result word changed while stalled");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .empty        (empty),
  .pop          (pop),
  .out_kind     (out_kind),
  .out_seq      (out_seq),
  .out_checksum (out_checksum),
  .out_last     (out_last)
);
